// ===== rtl/b64le_pkg.sv =====
// ----------------------------------------------------------------------------
// b64le_pkg: shared types and constants of the base64 line encoder
// Word types for both channels, the job word that links the front and the
// back, character codes and the sextet-to-ASCII mapping.
// ----------------------------------------------------------------------------
package b64le_pkg;

    // Job word limits
    localparam int JOB_CHARS = 6;
    localparam int CNT_W     = $clog2(JOB_CHARS + 1);

    // Job queue depth
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    // Line length register
    localparam int           LG_W     = 6;
    localparam logic [LG_W-1:0] LG_RESET = 6'd19;

    // Character codes
    localparam logic [7:0] CH_CR  = 8'd13;
    localparam logic [7:0] CH_LF  = 8'd10;
    localparam logic [7:0] CH_PAD = 8'd61;

    // Input word
    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } t_in;

    // Output word
    typedef struct packed {
        logic [7:0] out_char;
        logic       run_end;
        logic       stream_end;
    } t_out;

    // All characters caused by one input byte
    typedef struct packed {
        logic [JOB_CHARS-1:0][7:0] chars;
        logic [CNT_W-1:0]          cnt;
        logic                      fin;
    } t_job;

    // Map a sextet to its base64 character
    function automatic logic [7:0] enc_sextet(input logic [5:0] v);
        logic [7:0] w;
        w = {2'b00, v};
        if (v < 6'd26) begin
            enc_sextet = w + 8'd65;
        end else if (v < 6'd52) begin
            enc_sextet = w + 8'd71;
        end else if (v < 6'd62) begin
            enc_sextet = w - 8'd4;
        end else if (v == 6'd62) begin
            enc_sextet = 8'd43;
        end else begin
            enc_sextet = 8'd47;
        end
    endfunction

endpackage

// ===== rtl/b64le_front.sv =====
// ----------------------------------------------------------------------------
// b64le_front: byte intake and group tracking
// Takes one byte per word, tracks leftover bits, group phase and line fill,
// and builds the full character job for that byte.
// ----------------------------------------------------------------------------
module b64le_front (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  b64le_pkg::t_in           i_data,
    input  logic                     i_cfg_we,
    input  logic [b64le_pkg::LG_W-1:0] i_cfg_wdata,
    input  logic                     i_q_full,
    output logic                     o_push,
    output b64le_pkg::t_job          o_job
);
    import b64le_pkg::*;

    logic [LG_W-1:0] r_line_groups;
    logic [3:0]      r_carry, n_carry;
    logic [1:0]      r_phase, n_phase;
    logic [LG_W-1:0] r_gol, n_gol;

    logic [LG_W-1:0] gol_inc;
    logic            closed;
    logic [7:0]      b;
    t_job            job;

    assign o_stall = i_q_full;
    assign o_push  = i_valid && !i_q_full;
    assign b       = i_data.data_byte;
    assign gol_inc = r_gol + 1'b1;

    // Build the character job and the next group state
    always_comb begin
        job     = '0;
        n_carry = r_carry;
        n_phase = r_phase;
        n_gol   = r_gol;
        closed  = 1'b0;
        unique case (r_phase)
            2'd1: begin
                job.chars[0] = enc_sextet({r_carry[1:0], b[7:4]});
                job.cnt      = CNT_W'(1);
                n_carry      = b[3:0];
                n_phase      = 2'd2;
            end
            2'd2: begin
                job.chars[0] = enc_sextet({r_carry, b[7:6]});
                job.chars[1] = enc_sextet(b[5:0]);
                job.cnt      = CNT_W'(2);
                n_carry      = 4'd0;
                n_phase      = 2'd0;
                n_gol        = gol_inc;
                if (gol_inc == r_line_groups) begin
                    job.chars[2] = CH_CR;
                    job.chars[3] = CH_LF;
                    job.cnt      = CNT_W'(4);
                    n_gol        = '0;
                    closed       = 1'b1;
                end
            end
            default: begin
                job.chars[0] = enc_sextet(b[7:2]);
                job.cnt      = CNT_W'(1);
                n_carry      = {2'b00, b[1:0]};
                n_phase      = 2'd1;
            end
        endcase

        // Flush leftover bits, pad and close the line on the last byte
        if (i_data.final_byte) begin
            job.fin = 1'b1;
            if (n_phase == 2'd1) begin
                job.chars[job.cnt] = enc_sextet({n_carry[1:0], 4'b0000});
                job.chars[job.cnt + CNT_W'(1)] = CH_PAD;
                job.chars[job.cnt + CNT_W'(2)] = CH_PAD;
                job.cnt = job.cnt + CNT_W'(3);
            end else if (n_phase == 2'd2) begin
                job.chars[job.cnt] = enc_sextet({n_carry, 2'b00});
                job.chars[job.cnt + CNT_W'(1)] = CH_PAD;
                job.cnt = job.cnt + CNT_W'(2);
            end
            if (!closed) begin
                job.chars[job.cnt] = CH_CR;
                job.chars[job.cnt + CNT_W'(1)] = CH_LF;
                job.cnt = job.cnt + CNT_W'(2);
            end
            n_carry = 4'd0;
            n_phase = 2'd0;
            n_gol   = '0;
        end
    end

    assign o_job = job;

    // Hold the line length register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_groups <= LG_RESET;
        end else if (i_cfg_we) begin
            r_line_groups <= i_cfg_wdata;
        end
    end

    // Advance the group state on each accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_carry <= 4'd0;
            r_phase <= 2'd0;
            r_gol   <= '0;
        end else if (o_push) begin
            r_carry <= n_carry;
            r_phase <= n_phase;
            r_gol   <= n_gol;
        end
    end

endmodule

// ===== rtl/b64le_queue.sv =====
// ----------------------------------------------------------------------------
// b64le_queue: job queue between front and back
// Small first-in first-out store of character jobs so that intake and
// character output stall independently.
// ----------------------------------------------------------------------------
module b64le_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  b64le_pkg::t_job i_job,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output b64le_pkg::t_job o_job
);
    import b64le_pkg::*;

    t_job            r_mem [QDEPTH];
    logic [QAW-1:0]  r_wr_ptr;
    logic [QAW-1:0]  r_rd_ptr;
    logic [QCW-1:0]  r_cnt;

    assign o_full  = (r_cnt == QCW'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rd_ptr];

    // Store pushed jobs
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/b64le_back.sv =====
// ----------------------------------------------------------------------------
// b64le_back: character output
// Holds the current job and sends its characters one word per cycle while
// the output is not stalled, loading the next job as the last character leaves.
// ----------------------------------------------------------------------------
module b64le_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_empty,
    input  b64le_pkg::t_job i_job,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_stall,
    output b64le_pkg::t_out o_data
);
    import b64le_pkg::*;

    logic             r_busy;
    t_job             r_job;
    logic [CNT_W-1:0] r_idx;

    logic last;
    logic take;

    assign last    = (r_idx == r_job.cnt - CNT_W'(1));
    assign take    = r_busy && !i_stall;
    assign o_pop   = !i_q_empty && (!r_busy || (take && last));
    assign o_valid = r_busy;

    // Present the current character
    always_comb begin
        o_data.out_char   = r_job.chars[r_idx];
        o_data.run_end    = last;
        o_data.stream_end = last && r_job.fin;
    end

    // Load the job register
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end
    end

    // Advance through the characters of the job
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (take) begin
            if (last) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

endmodule

// ===== rtl/base64_line_encoder_top.sv =====
// ----------------------------------------------------------------------------
// base64_line_encoder_top: base64 encoder with CR LF line breaks
// Encodes a byte stream into base64 characters, one character per output
// word, with CR LF after every line_groups three-byte groups and a padded,
// CR LF closed tail on the byte marked final.
// ----------------------------------------------------------------------------
// Each input byte is turned into its full run of one to six characters in
// the cycle it is accepted and placed in a four-entry job queue; a byte is
// accepted in any cycle the queue has room. The output side sends one
// character per cycle while the output is not stalled and jobs are queued,
// without gaps between runs, so the sustained rate is set by the output.
// The line length register resets to 19 groups (76 characters); the user
// must see that it is written only while idle, as the block does not enforce it.
module base64_line_encoder_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  b64le_pkg::t_in             i_data,
    output logic                       o_valid,
    input  logic                       i_stall,
    output b64le_pkg::t_out            o_data,
    input  logic                       i_cfg_we,
    input  logic [b64le_pkg::LG_W-1:0] i_cfg_wdata
);
    import b64le_pkg::*;

    logic q_full;
    logic q_empty;
    logic push;
    logic pop;
    t_job push_job;
    t_job head_job;

    // Intake and grouping
    b64le_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data      (i_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_job       (push_job)
    );

    // Job queue
    b64le_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_job   (head_job)
    );

    // Character output
    b64le_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_job     (head_job),
        .o_pop     (pop),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_data    (o_data)
    );

endmodule
